>>> design/two_class_oldest_first_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// two_class_oldest_first_queue_unit_defines.svh
// Assertion macros of the queue unit module. Each macro samples on the
// rising edge of clock and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_OLDEST_FIRST_QUEUE_UNIT_DEFINES_SVH
`define TWO_CLASS_OLDEST_FIRST_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication
`define OFQ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ofq assertion failed: same-cycle check");

// Next-cycle implication
`define OFQ_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ofq assertion failed: next-cycle check");

`endif

>>> design/ofq_pkg.sv
// ----------------------------------------------------------------------------
// ofq_pkg
// Shared types, codes and default sizes of the two-class oldest-first queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ofq_pkg;

   // Default sizes for the top-level parameters
   localparam int DEF_QUEUE_DEPTH   = 16;
   localparam int DEF_PAYLOAD_WIDTH = 16;

   // Fixed field widths
   localparam int STAMP_W   = 8;
   localparam int TAG_W     = 16;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQ_ANY = 2'd1,
      CMD_DEQ_C0  = 2'd2,
      CMD_DEQ_C1  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One result item as it travels to the output stage
   typedef struct packed {
      logic [TAG_W-1:0] payload;
      logic             cls;
      status_type       status;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/two_class_oldest_first_queue_unit.sv
// ----------------------------------------------------------------------------
// two_class_oldest_first_queue_unit
// Two class FIFOs sharing one arrival counter. Enqueue stamps the tag and
// appends it to its class; dequeue pops a class head or the older head.
//
//   channel   ports                                          direction
//   req       req_command, req_item_class, req_payload       in
//   rsp       rsp_out_payload, rsp_out_class, rsp_status     out
//
// An item passes through the accept state, in which both head entries are read,
// and then the execute state, in which the read data returns from the entry
// memories and the pointers, counter and entry write are updated.
// A new item is accepted after the execute state ends, which orders every
// memory write before the next head read.
// The execute state holds while the output register is full and not drained.
// Reset clears pointers, counter and control; entries need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_oldest_first_queue_unit #(
   parameter int QUEUE_DEPTH   = ofq_pkg::DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_WIDTH = ofq_pkg::DEF_PAYLOAD_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ofq_pkg::CMD_W-1:0]     req_command,
   input  wire logic                          req_item_class,
   input  wire logic [ofq_pkg::TAG_W-1:0]     req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ofq_pkg::TAG_W-1:0]          rsp_out_payload,
   output logic                               rsp_out_class,
   output logic [ofq_pkg::STATUS_W-1:0]       rsp_status
);

`include "two_class_oldest_first_queue_unit_defines.svh"

   localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int ENTRY_W = ofq_pkg::STAMP_W + PAYLOAD_WIDTH;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                      state_ff, state_in;
   ofq_pkg::cmd_type               cmd_ff;
   logic                           class_ff;
   logic [ofq_pkg::TAG_W-1:0]      payload_ff;

   // Pointers: slot plus lap bit
   logic [SLOT_W-1:0] c0_head_slot_ff, c0_head_slot_in, c0_tail_slot_ff, c0_tail_slot_in;
   logic [SLOT_W-1:0] c1_head_slot_ff, c1_head_slot_in, c1_tail_slot_ff, c1_tail_slot_in;
   logic              c0_head_lap_ff, c0_head_lap_in, c0_tail_lap_ff, c0_tail_lap_in;
   logic              c1_head_lap_ff, c1_head_lap_in, c1_tail_lap_ff, c1_tail_lap_in;
   logic [ofq_pkg::STAMP_W-1:0] arrival_ff, arrival_in;

   logic [ENTRY_W-1:0]          rd_data0, rd_data1, wr_data;
   logic [ofq_pkg::STAMP_W-1:0] stamp0, stamp1, stamp_diff;
   logic                        have0, have1, full0, full1, enq_full;
   logic                        enq_ok, deq_ok, deq_sel, exec_done, stage_free;
   logic                        wr_en0, wr_en1;
   ofq_pkg::rsp_type            result, rsp_data;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
      return (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   // Accept only between items
   assign req_ready = (state_ff == S_IDLE);
   assign exec_done = (state_ff == S_EXEC) && stage_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: if (stage_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff     <= ofq_pkg::cmd_type'(req_command);
         class_ff   <= req_item_class;
         payload_ff <= req_payload;
      end
   end

   // Queue occupancy
   assign have0 = (c0_head_slot_ff != c0_tail_slot_ff) || (c0_head_lap_ff != c0_tail_lap_ff);
   assign have1 = (c1_head_slot_ff != c1_tail_slot_ff) || (c1_head_lap_ff != c1_tail_lap_ff);
   assign full0 = (c0_head_slot_ff == c0_tail_slot_ff) && (c0_head_lap_ff != c0_tail_lap_ff);
   assign full1 = (c1_head_slot_ff == c1_tail_slot_ff) && (c1_head_lap_ff != c1_tail_lap_ff);
   assign enq_full = class_ff ? full1 : full0;

   // Wrap-aware stamp compare of the two heads
   assign stamp0     = rd_data0[ENTRY_W-1 -: ofq_pkg::STAMP_W];
   assign stamp1     = rd_data1[ENTRY_W-1 -: ofq_pkg::STAMP_W];
   assign stamp_diff = stamp1 - stamp0;

   // Decide the command
   always_comb begin
      enq_ok  = 1'b0;
      deq_ok  = 1'b0;
      deq_sel = 1'b0;
      case (cmd_ff)
         ofq_pkg::CMD_ENQUEUE: enq_ok = !enq_full;
         ofq_pkg::CMD_DEQ_C0: begin
            deq_ok = have0;
         end
         ofq_pkg::CMD_DEQ_C1: begin
            deq_ok  = have1;
            deq_sel = 1'b1;
         end
         ofq_pkg::CMD_DEQ_ANY: begin
            deq_ok = have0 || have1;
            if (have0 && have1) begin
               deq_sel = stamp_diff[ofq_pkg::STAMP_W-1];
            end else begin
               deq_sel = have1;
            end
         end
         default: begin
            deq_ok = 1'b0;
         end
      endcase
   end

   // Build the result item
   always_comb begin
      result.payload = '0;
      result.cls     = 1'b0;
      result.status  = ofq_pkg::ST_OK;
      if (cmd_ff == ofq_pkg::CMD_ENQUEUE) begin
         if (!enq_ok) begin
            result.status = ofq_pkg::ST_FULL;
         end
      end else if (deq_ok) begin
         result.cls     = deq_sel;
         result.payload = deq_sel ? ofq_pkg::TAG_W'(rd_data1[PAYLOAD_WIDTH-1:0])
                                  : ofq_pkg::TAG_W'(rd_data0[PAYLOAD_WIDTH-1:0]);
      end else begin
         result.status = ofq_pkg::ST_EMPTY;
      end
   end

   // Advance pointers and counter
   always_comb begin
      c0_head_slot_in = c0_head_slot_ff;
      c0_head_lap_in  = c0_head_lap_ff;
      c0_tail_slot_in = c0_tail_slot_ff;
      c0_tail_lap_in  = c0_tail_lap_ff;
      c1_head_slot_in = c1_head_slot_ff;
      c1_head_lap_in  = c1_head_lap_ff;
      c1_tail_slot_in = c1_tail_slot_ff;
      c1_tail_lap_in  = c1_tail_lap_ff;
      arrival_in      = arrival_ff;
      if (exec_done && enq_ok) begin
         arrival_in = arrival_ff + 1'b1;
         if (class_ff) begin
            c1_tail_slot_in = next_slot(c1_tail_slot_ff);
            c1_tail_lap_in  = c1_tail_lap_ff ^ (c1_tail_slot_ff == LAST_SLOT);
         end else begin
            c0_tail_slot_in = next_slot(c0_tail_slot_ff);
            c0_tail_lap_in  = c0_tail_lap_ff ^ (c0_tail_slot_ff == LAST_SLOT);
         end
      end
      if (exec_done && deq_ok) begin
         if (deq_sel) begin
            c1_head_slot_in = next_slot(c1_head_slot_ff);
            c1_head_lap_in  = c1_head_lap_ff ^ (c1_head_slot_ff == LAST_SLOT);
         end else begin
            c0_head_slot_in = next_slot(c0_head_slot_ff);
            c0_head_lap_in  = c0_head_lap_ff ^ (c0_head_slot_ff == LAST_SLOT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_head_slot_ff <= '0;
         c0_head_lap_ff  <= 1'b0;
         c0_tail_slot_ff <= '0;
         c0_tail_lap_ff  <= 1'b0;
         c1_head_slot_ff <= '0;
         c1_head_lap_ff  <= 1'b0;
         c1_tail_slot_ff <= '0;
         c1_tail_lap_ff  <= 1'b0;
         arrival_ff      <= '0;
      end else begin
         c0_head_slot_ff <= c0_head_slot_in;
         c0_head_lap_ff  <= c0_head_lap_in;
         c0_tail_slot_ff <= c0_tail_slot_in;
         c0_tail_lap_ff  <= c0_tail_lap_in;
         c1_head_slot_ff <= c1_head_slot_in;
         c1_head_lap_ff  <= c1_head_lap_in;
         c1_tail_slot_ff <= c1_tail_slot_in;
         c1_tail_lap_ff  <= c1_tail_lap_in;
         arrival_ff      <= arrival_in;
      end
   end

   // Stamp and write the new entry at the tail
   assign wr_data = {arrival_ff, PAYLOAD_WIDTH'(payload_ff)};
   assign wr_en0  = exec_done && enq_ok && !class_ff;
   assign wr_en1  = exec_done && enq_ok && class_ff;

   ofq_store #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_store0 (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (c0_tail_slot_ff),
      .wr_data (wr_data),
      .rd_addr (c0_head_slot_ff),
      .rd_data (rd_data0)
   );

   ofq_store #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_store1 (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (c1_tail_slot_ff),
      .wr_data (wr_data),
      .rd_addr (c1_head_slot_ff),
      .rd_data (rd_data1)
   );

   ofq_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (exec_done),
      .load_data (result),
      .free      (stage_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_payload = rsp_data.payload;
   assign rsp_out_class   = rsp_data.cls;
   assign rsp_status      = rsp_data.status;

   // Checks
   `OFQ_ASSERT_NXT(a_accept_to_exec, req_valid && req_ready, state_ff == S_EXEC)
   `OFQ_ASSERT_NXT(a_done_shows_result, exec_done, rsp_valid)
   `OFQ_ASSERT_IMP(a_slots_in_range, 1'b1, (c0_head_slot_ff <= LAST_SLOT) && (c0_tail_slot_ff <= LAST_SLOT) && (c1_head_slot_ff <= LAST_SLOT) && (c1_tail_slot_ff <= LAST_SLOT))
   `OFQ_ASSERT_NXT(a_counter_only_on_enqueue, !(exec_done && enq_ok), arrival_ff == $past(arrival_ff))

endmodule

`default_nettype wire

>>> design/ofq_store.sv
// ----------------------------------------------------------------------------
// ofq_store
// Entry memory of one class queue: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ofq_store #(
   parameter int DEPTH = ofq_pkg::DEF_QUEUE_DEPTH,
   parameter int WIDTH = ofq_pkg::STAMP_W + ofq_pkg::DEF_PAYLOAD_WIDTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/ofq_rsp_stage.sv
// ----------------------------------------------------------------------------
// ofq_rsp_stage
// Output register of the result channel. Holds one result until the
// transfer and reports when it can take the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module ofq_rsp_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire ofq_pkg::rsp_type     load_data,
   output logic                      free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ofq_pkg::rsp_type          rsp_data
);

   logic             valid_ff, valid_in;
   ofq_pkg::rsp_type data_ff;

   // Room when empty or when the held result leaves this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

>>> test/two_class_oldest_first_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// two_class_oldest_first_queue_unit_tb
// Self-checking bench for the two-class oldest-first queue. A short directed
// drill walks the empty, full, one-side-empty and oldest-head cases. Random
// command streams follow that fill, drain and churn the class queues across
// arrival counter wrap. Both channels idle at random. Every result is compared
// in order against a fixed drill result or a queue-based model of the block.
// ----------------------------------------------------------------------------
module two_class_oldest_first_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ofq_pkg::*;

   localparam int DEPTH           = DEF_QUEUE_DEPTH;
   localparam int RANDOM_COMMANDS = 1025;
   localparam int HOLD_CYCLES     = 300;

   localparam rsp_type OK_RSP    = '{payload: '0, cls: 1'b0, status: ST_OK};
   localparam rsp_type EMPTY_RSP = '{payload: '0, cls: 1'b0, status: ST_EMPTY};
   localparam rsp_type FULL_RSP  = '{payload: '0, cls: 1'b0, status: ST_FULL};

   // One held item: arrival stamp above its tag
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   tag;
   } shelter_entry;

   // One line of the directed drill; reps repeats it with the tag counting up
   typedef struct {
      cmd_type          cmd;
      logic             cls;
      logic [TAG_W-1:0] tag;
      int               reps;
      bit               fixed;
      rsp_type          want;
   } drill_row;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command;
   logic                req_item_class;
   logic [TAG_W-1:0]    req_payload;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [TAG_W-1:0]    rsp_out_payload;
   logic                rsp_out_class;
   logic [STATUS_W-1:0] rsp_status;

   shelter_entry        dog_q[$];
   shelter_entry        cat_q[$];
   logic [STAMP_W-1:0]  arrivals = '0;
   rsp_type             pending_rsp[$];
   int                  checked_count = 0;
   drill_row            drill[$];
   int                  mismatch_count = 0;
   bit                  hold_request = 1'b0;

   two_class_oldest_first_queue_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_item_class  (req_item_class),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_class   (rsp_out_class),
      .rsp_status      (rsp_status)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Advance the queue state by one command and return the result it yields
   function automatic rsp_type apply_command(cmd_type cmd, logic cls, logic [TAG_W-1:0] tag);
      rsp_type            r;
      shelter_entry       e;
      logic [STAMP_W-1:0] d;
      bit                 have_dog;
      bit                 have_cat;
      bit                 found;
      bit                 take_cat;
      r        = OK_RSP;
      have_dog = dog_q.size() != 0;
      have_cat = cat_q.size() != 0;
      found    = 1'b1;
      take_cat = 1'b0;
      case (cmd)
         CMD_ENQUEUE: begin
            // refuse at depth; the counter holds
            if ((cls ? cat_q.size() : dog_q.size()) >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               e = '{stamp: arrivals, tag: tag};
               if (cls) begin
                  cat_q.insert(cat_q.size(), e);
               end else begin
                  dog_q.insert(dog_q.size(), e);
               end
               arrivals = arrivals + 1'b1;
            end
            return r;
         end
         CMD_DEQ_C0: begin
            found = have_dog;
         end
         CMD_DEQ_C1: begin
            take_cat = 1'b1;
            found    = have_cat;
         end
         default: begin
            // both heads present: cat wins when its stamp is ahead of dog's by
            // half the counter range or more (wrap-aware older test)
            if (have_dog && have_cat) begin
               d        = cat_q[0].stamp - dog_q[0].stamp;
               take_cat = d[STAMP_W-1];
            end else begin
               take_cat = have_cat;
               found    = have_dog || have_cat;
            end
         end
      endcase
      if (!found) begin
         r.status = ST_EMPTY;
      end else if (take_cat) begin
         e         = cat_q[0];
         cat_q.delete(0);
         r.payload = e.tag;
         r.cls     = 1'b1;
      end else begin
         e         = dog_q[0];
         dog_q.delete(0);
         r.payload = e.tag;
      end
      return r;
   endfunction

   // Offer one command, hold it until the transfer, then log its expected result
   task automatic offer_command(cmd_type cmd, logic cls, logic [TAG_W-1:0] tag, bit idle,
                                bit fixed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = idle ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_item_class <= cls;
      req_payload    <= tag;
      do @(posedge clock); while (!req_ready);
      predicted = apply_command(cmd, cls, tag);
      pending_rsp.insert(pending_rsp.size(), fixed ? want : predicted);
   endtask

   // Stimulus: reset, directed drill, random streams, drain
   initial begin
      int               sent;
      int               mode;
      int               span;
      int               roll;
      int               enq_pct;
      bit               idle;
      logic             churn_cls;
      logic             cls;
      logic [TAG_W-1:0] tag;
      cmd_type          cmd;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_ENQUEUE;
      req_item_class = 1'b0;
      req_payload    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty on every dequeue, oldest-first across classes, fill to full,
      // then any-class dequeue with the dog side empty
      drill.insert(drill.size(), '{CMD_DEQ_ANY, 1'b0, 16'h0000, 1, 1'b1, EMPTY_RSP});
      drill.insert(drill.size(), '{CMD_DEQ_C0, 1'b1, 16'hFFFF, 1, 1'b1, EMPTY_RSP});
      drill.insert(drill.size(), '{CMD_DEQ_C1, 1'b0, 16'hFFFF, 1, 1'b1, EMPTY_RSP});
      drill.insert(drill.size(), '{CMD_ENQUEUE, 1'b0, 16'hFFFF, 1, 1'b1, OK_RSP});
      drill.insert(drill.size(), '{CMD_ENQUEUE, 1'b1, 16'h0000, 1, 1'b1, OK_RSP});
      drill.insert(drill.size(), '{CMD_DEQ_ANY, 1'b0, 16'h0000, 1, 1'b1,
                                   '{payload: 16'hFFFF, cls: 1'b0, status: ST_OK}});
      drill.insert(drill.size(), '{CMD_DEQ_ANY, 1'b1, 16'h0000, 1, 1'b1,
                                   '{payload: 16'h0000, cls: 1'b1, status: ST_OK}});
      drill.insert(drill.size(), '{CMD_ENQUEUE, 1'b1, 16'h8001, DEPTH, 1'b1, OK_RSP});
      drill.insert(drill.size(), '{CMD_ENQUEUE, 1'b1, 16'h5555, 1, 1'b1, FULL_RSP});
      drill.insert(drill.size(), '{CMD_DEQ_ANY, 1'b0, 16'hAAAA, 1, 1'b1,
                                   '{payload: 16'h8001, cls: 1'b1, status: ST_OK}});
      foreach (drill[row]) begin
         for (int k = 0; k < drill[row].reps; k++) begin
            offer_command(drill[row].cmd, drill[row].cls, TAG_W'(drill[row].tag + k), 1'b1,
                          drill[row].fixed, drill[row].want);
         end
      end

      // Random blocks: balanced, fill-heavy, drain-heavy, noise, one-class churn
      sent = 0;
      while (sent < RANDOM_COMMANDS) begin
         mode      = $urandom_range(0, 9);
         span      = (mode == 9) ? $urandom_range(150, 300) : $urandom_range(20, 60);
         idle      = $urandom_range(0, 3) != 0;
         churn_cls = 1'($urandom_range(0, 1));
         case (mode)
            4, 5:    enq_pct = 85;
            6, 7:    enq_pct = 15;
            8:       enq_pct = 25;
            default: enq_pct = 50;
         endcase
         for (int i = 0; i < span && sent < RANDOM_COMMANDS; i++) begin
            roll = $urandom_range(0, 99);
            cls  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
               tag = $urandom_range(0, 1) ? '1 : '0;
            end else begin
               tag = TAG_W'($urandom);
            end
            if (roll < enq_pct) begin
               cmd = CMD_ENQUEUE;
               if (mode == 9) begin
                  cls = churn_cls;
               end
            end else if (mode == 9) begin
               // keep one head waiting while the other class cycles the counter
               if (roll % 10 == 0) begin
                  cmd = CMD_DEQ_ANY;
               end else begin
                  cmd = churn_cls ? CMD_DEQ_C1 : CMD_DEQ_C0;
               end
            end else begin
               case ($urandom_range(0, 2))
                  0:       cmd = CMD_DEQ_ANY;
                  1:       cmd = CMD_DEQ_C0;
                  default: cmd = CMD_DEQ_C1;
               endcase
            end
            if (sent == 200) begin
               hold_request = 1'b1;
            end
            offer_command(cmd, cls, tag, idle, 1'b0, OK_RSP);
            sent++;
         end
      end
      req_valid <= 1'b0;

      // Drain, then wait for stray results
      while (checked_count < pending_rsp.size()) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Result side: random ready runs and stalls, plus one long hold-off on request
   initial begin
      int run_cnt;
      int stall_cnt;
      int hold_cnt;
      bit hold_taken;
      run_cnt    = 0;
      stall_cnt  = 0;
      hold_cnt   = 0;
      hold_taken = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt   = HOLD_CYCLES;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (run_cnt > 0) begin
            run_cnt--;
            rsp_ready <= 1'b1;
         end else if (stall_cnt > 0) begin
            stall_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            run_cnt   = $urandom_range(0, 24);
            stall_cnt = idle_length();
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare every result transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (checked_count >= pending_rsp.size()) begin
            $display("%0t: unexpected result: payload %h class %0d status %0d",
                     $time, rsp_out_payload, rsp_out_class, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_rsp[checked_count];
            checked_count++;
            if (rsp_out_payload !== want.payload) begin
               $display("%0t: payload expected %h actual %h",
                        $time, want.payload, rsp_out_payload);
               mismatch_count++;
            end
            if (rsp_out_class !== want.cls) begin
               $display("%0t: class expected %0d actual %0d",
                        $time, want.cls, rsp_out_class);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/ofq_pkg.sv
design/ofq_store.sv
design/ofq_rsp_stage.sv
design/two_class_oldest_first_queue_unit.sv
test/two_class_oldest_first_queue_unit_tb.sv
